@@ hdl/pcs_pkg.sv @@
// Shared constants, widths and types of the PUCT child select unit.
package pcs_pkg;

    localparam int MAX_CHILDREN = 256;
    localparam int VISIT_BITS   = 16;
    localparam int VISIT_KEEP   = (VISIT_BITS < 16) ? VISIT_BITS : 16;
    localparam logic [15:0] VISIT_MASK = 16'((32'd1 << VISIT_KEEP) - 32'd1);

    localparam int POS_W    = $clog2(MAX_CHILDREN + 1);
    localparam int SUM_W    = 33;
    localparam int VIS_W    = 16;
    localparam int PRIOR_W  = 17;
    localparam int WEIGHT_W = 16;
    localparam int INDEX_W  = 8;
    localparam int SCORE_W  = 30;

    localparam int DIVIDEND_W = 33;
    localparam int DIVISOR_W  = 17;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    localparam int ROOT_W     = 24;
    localparam int ROOT_REM_W = ROOT_W + 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);

    localparam int COEF_W  = PRIOR_W + WEIGHT_W;
    localparam int ACC_W   = COEF_W + ROOT_W;
    localparam int E_SHIFT = 28;
    localparam int E_W     = ACC_W - E_SHIFT;
    localparam int WIDE_W  = DIVIDEND_W + 2;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0]  WIDE_MIN  = WIDE_W'(SCORE_MIN);
    localparam logic signed [WIDE_W-1:0]  WIDE_MAX  = WIDE_W'(SCORE_MAX);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd8192;

    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_EXPLORATION = 1'b0;

    typedef logic signed [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic                        start;
        logic signed [SUM_W-1:0]     child_sum;
        logic [VIS_W-1:0]            visits;
        logic [PRIOR_W-1:0]          prior;
        logic [VIS_W-1:0]            parent;
        logic [WEIGHT_W-1:0]         weight;
    } req_t;

    typedef struct packed {
        logic   done;
        score_t score;
    } rsp_t;

    typedef enum logic [3:0] {
        CS_IDLE = 4'b0001,
        CS_ROOT = 4'b0010,
        CS_EDIV = 4'b0100,
        CS_SUM  = 4'b1000
    } core_state_t;

    typedef enum logic [2:0] {
        TS_IDLE = 3'b001,
        TS_CALC = 3'b010,
        TS_DONE = 3'b100
    } top_state_t;

endpackage

@@ hdl/pcs_div_serial.sv @@
// Restoring divider that produces one quotient bit per cycle.
module pcs_div_serial (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pcs_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [pcs_pkg::DIVISOR_W-1:0]    divisor,
    output logic                             done,
    output logic [pcs_pkg::DIVIDEND_W-1:0]   quotient
);

    logic                             busy_reg;
    logic [pcs_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [pcs_pkg::DIVIDEND_W-1:0]   quo_reg;
    logic [pcs_pkg::DIVIDEND_W-1:0]   quo_next;
    logic [pcs_pkg::DIVISOR_W-1:0]    rem_reg;
    logic [pcs_pkg::DIVISOR_W-1:0]    rem_next;
    logic [pcs_pkg::DIVISOR_W-1:0]    den_reg;
    logic [pcs_pkg::DIVISOR_W:0]      rem_shift;
    logic                             fits;
    logic                             last_step;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[pcs_pkg::DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_next  = fits ? pcs_pkg::DIVISOR_W'(rem_shift - {1'b0, den_reg})
                         : rem_shift[pcs_pkg::DIVISOR_W-1:0];
        quo_next  = {quo_reg[pcs_pkg::DIVIDEND_W-2:0], fits};
        last_step = cnt_reg == pcs_pkg::DIV_CNT_W'(pcs_pkg::DIVIDEND_W - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = busy_reg && last_step;
    assign quotient = quo_reg;

endmodule

@@ hdl/pcs_sqrt_serial.sv @@
// Digit-by-digit square root of parent_visits * 2^32, one root bit per cycle, MSB first.
module pcs_sqrt_serial (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pcs_pkg::VIS_W-1:0]    radicand,
    output logic                         bit_valid,
    output logic                         root_bit,
    output logic                         done
);

    logic                              busy_reg;
    logic [pcs_pkg::ROOT_CNT_W-1:0]    cnt_reg;
    logic [pcs_pkg::VIS_W-1:0]         rad_reg;
    logic [pcs_pkg::ROOT_REM_W-1:0]    rem_reg;
    logic [pcs_pkg::ROOT_REM_W-1:0]    rem_next;
    logic [pcs_pkg::ROOT_W-1:0]        root_reg;
    logic [pcs_pkg::ROOT_REM_W+1:0]    rem_shift;
    logic [pcs_pkg::ROOT_REM_W+1:0]    trial;
    logic                              fits;
    logic                              last_step;

    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[pcs_pkg::VIS_W-1 -: 2]};
        trial     = (pcs_pkg::ROOT_REM_W + 2)'({root_reg, 2'b01});
        fits      = rem_shift >= trial;
        rem_next  = fits ? pcs_pkg::ROOT_REM_W'(rem_shift - trial)
                         : rem_shift[pcs_pkg::ROOT_REM_W-1:0];
        last_step = cnt_reg == pcs_pkg::ROOT_CNT_W'(pcs_pkg::ROOT_W - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[pcs_pkg::VIS_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[pcs_pkg::ROOT_W-2:0], fits};
        end
    end

    assign bit_valid = busy_reg;
    assign root_bit  = fits;
    assign done      = busy_reg && last_step;

endmodule

@@ hdl/pcs_score_core.sv @@
// Score of one child: serial root, shift-add product, two serial divides, saturating sum.
module pcs_score_core (
    input  logic            clk,
    input  logic            rst_n,
    input  pcs_pkg::req_t   req,
    output pcs_pkg::rsp_t   rsp
);

    pcs_pkg::core_state_t              state_reg;
    pcs_pkg::core_state_t              state_next;

    logic                              neg_reg;
    logic                              vis_zero_reg;
    logic [pcs_pkg::DIVISOR_W-1:0]     vis1_reg;
    logic [pcs_pkg::COEF_W-1:0]        coef_reg;
    logic [pcs_pkg::ACC_W-1:0]         acc_reg;
    logic [pcs_pkg::ACC_W-1:0]         acc_next;
    logic                              done_reg;
    pcs_pkg::score_t                   score_reg;
    pcs_pkg::score_t                   score_next;

    logic [pcs_pkg::VIS_W-1:0]         visits_m;
    logic [pcs_pkg::VIS_W-1:0]         parent_m;
    logic [pcs_pkg::SUM_W-1:0]         raw_sum;
    logic [pcs_pkg::SUM_W-1:0]         mag;

    logic                              root_valid;
    logic                              root_bit;
    logic                              root_done;
    logic                              qdiv_done;
    logic [pcs_pkg::DIVIDEND_W-1:0]    q_quo;
    logic                              ediv_done;
    logic [pcs_pkg::DIVIDEND_W-1:0]    e_quo;

    logic signed [pcs_pkg::WIDE_W-1:0] q_wide;
    logic signed [pcs_pkg::WIDE_W-1:0] e_wide;
    logic signed [pcs_pkg::WIDE_W-1:0] sum_wide;

    always_comb
    begin
        visits_m = req.visits & pcs_pkg::VISIT_MASK;
        parent_m = req.parent & pcs_pkg::VISIT_MASK;
        raw_sum  = req.child_sum;
        mag      = raw_sum[pcs_pkg::SUM_W-1] ? pcs_pkg::SUM_W'(~raw_sum + 1'b1) : raw_sum;
        acc_next = {acc_reg[pcs_pkg::ACC_W-2:0], 1'b0}
                 + (root_bit ? pcs_pkg::ACC_W'(coef_reg) : '0);
    end

    pcs_sqrt_serial u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req.start),
        .radicand  (parent_m),
        .bit_valid (root_valid),
        .root_bit  (root_bit),
        .done      (root_done)
    );

    pcs_div_serial u_qdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (req.start),
        .dividend (mag),
        .divisor  (pcs_pkg::DIVISOR_W'(visits_m)),
        .done     (qdiv_done),
        .quotient (q_quo)
    );

    pcs_div_serial u_ediv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_done),
        .dividend (pcs_pkg::DIVIDEND_W'(acc_next[pcs_pkg::ACC_W-1:pcs_pkg::E_SHIFT])),
        .divisor  (vis1_reg),
        .done     (ediv_done),
        .quotient (e_quo)
    );

    always_comb
    begin
        if (vis_zero_reg)
        begin
            q_wide = '0;
        end
        else if (neg_reg)
        begin
            q_wide = -$signed({2'b00, q_quo});
        end
        else
        begin
            q_wide = $signed({2'b00, q_quo});
        end
        e_wide   = $signed(pcs_pkg::WIDE_W'(e_quo[pcs_pkg::E_W-1:0]));
        sum_wide = q_wide + e_wide;
        if (sum_wide > pcs_pkg::WIDE_MAX)
        begin
            score_next = pcs_pkg::SCORE_MAX;
        end
        else if (sum_wide < pcs_pkg::WIDE_MIN)
        begin
            score_next = pcs_pkg::SCORE_MIN;
        end
        else
        begin
            score_next = pcs_pkg::SCORE_W'(sum_wide);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcs_pkg::CS_IDLE:
            begin
                if (req.start)
                begin
                    state_next = pcs_pkg::CS_ROOT;
                end
            end
            pcs_pkg::CS_ROOT:
            begin
                if (root_done)
                begin
                    state_next = pcs_pkg::CS_EDIV;
                end
            end
            pcs_pkg::CS_EDIV:
            begin
                if (ediv_done && !qdiv_done)
                begin
                    state_next = pcs_pkg::CS_SUM;
                end
            end
            pcs_pkg::CS_SUM:
            begin
                state_next = pcs_pkg::CS_IDLE;
            end
            default:
            begin
                state_next = pcs_pkg::CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcs_pkg::CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == pcs_pkg::CS_SUM;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg      <= raw_sum[pcs_pkg::SUM_W-1];
            vis_zero_reg <= visits_m == '0;
            vis1_reg     <= pcs_pkg::DIVISOR_W'(visits_m) + 1'b1;
            coef_reg     <= pcs_pkg::COEF_W'(req.prior) * pcs_pkg::COEF_W'(req.weight);
            acc_reg      <= '0;
        end
        else if (root_valid)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == pcs_pkg::CS_SUM)
        begin
            score_reg <= score_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.score = score_reg;

endmodule

@@ hdl/puct_child_select_unit.sv @@
// Top level of the PUCT child select unit: handshake, register port, running best.
//
// Children of one node arrive on the child channel (child_valid / child_stall),
// one transfer per child, with the parent's visit count repeated on each.
// The unit scores each child and keeps the strictly greatest score; the first
// child wins ties. A transfer with last_child set ends the node: one result
// transfer (chosen_index, best_score) follows on the result channel and the
// running state clears for the next node.
// Each scored child passes in order from its transfer to the next free slot
// through the serial square root (one root bit per cycle, while the
// product is accumulated), the serial divider that forms the exploration
// term, and the sum, compare and handoff steps.
// child_stall is high whenever the unit is not idle: while a child is scored
// and while a node end waits for the output register.
// The result sits in an output register; a stalled result holds there while
// the next child is taken and scored, and a node end waits only if the
// register is still full. Children past MAX_CHILDREN are not scored.
// Reset clears the running best, the child count and the output valid, and
// sets exploration_weight to 2.0 (Q4.12). Write exploration_weight only while idle.
module puct_child_select_unit (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pcs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,

    input  logic                               child_valid,
    output logic                               child_stall,
    input  logic signed [pcs_pkg::SUM_W-1:0]   child_value_sum,
    input  logic [pcs_pkg::VIS_W-1:0]          child_visits,
    input  logic [pcs_pkg::PRIOR_W-1:0]        child_prior,
    input  logic [pcs_pkg::VIS_W-1:0]          parent_visits,
    input  logic                               last_child,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [pcs_pkg::INDEX_W-1:0]        chosen_index,
    output logic signed [pcs_pkg::SCORE_W-1:0] best_score
);

    pcs_pkg::top_state_t               state_reg;
    pcs_pkg::top_state_t               state_next;
    logic [pcs_pkg::WEIGHT_W-1:0]      weight_reg;
    logic [pcs_pkg::POS_W-1:0]         pos_reg;
    logic [pcs_pkg::POS_W-1:0]         pos_next;
    pcs_pkg::score_t                   run_score_reg;
    pcs_pkg::score_t                   run_score_next;
    logic [pcs_pkg::INDEX_W-1:0]       run_idx_reg;
    logic [pcs_pkg::INDEX_W-1:0]       run_idx_next;
    logic                              last_reg;
    logic                              last_next;
    logic                              result_valid_reg;
    logic                              result_valid_next;
    logic [pcs_pkg::INDEX_W-1:0]       chosen_index_reg;
    pcs_pkg::score_t                   best_score_reg;

    logic                              accept;
    logic                              out_free;
    logic                              load_out;
    logic                              cfg_write;
    pcs_pkg::req_t                     req;
    pcs_pkg::rsp_t                     rsp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                    && (paddr[2:2] == pcs_pkg::REG_EXPLORATION);
    assign prdata    = (paddr[2:2] == pcs_pkg::REG_EXPLORATION)
                     ? 32'(weight_reg) : 32'd0;

    assign child_stall = state_reg != pcs_pkg::TS_IDLE;
    assign accept      = child_valid && !child_stall;
    assign out_free    = !result_valid_reg || !result_stall;

    always_comb
    begin
        req.start     = accept && (pos_reg < pcs_pkg::POS_W'(pcs_pkg::MAX_CHILDREN));
        req.child_sum = child_value_sum;
        req.visits    = child_visits;
        req.prior     = child_prior;
        req.parent    = parent_visits;
        req.weight    = weight_reg;
    end

    pcs_score_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        run_score_next    = run_score_reg;
        run_idx_next      = run_idx_reg;
        last_next         = last_reg;
        result_valid_next = result_valid_reg && result_stall;
        load_out          = 1'b0;
        case (state_reg)
            pcs_pkg::TS_IDLE:
            begin
                if (accept)
                begin
                    last_next  = last_child;
                    state_next = req.start ? pcs_pkg::TS_CALC : pcs_pkg::TS_DONE;
                end
            end
            pcs_pkg::TS_CALC:
            begin
                if (rsp.done)
                begin
                    if ((pos_reg == '0) || (rsp.score > run_score_reg))
                    begin
                        run_score_next = rsp.score;
                        run_idx_next   = pcs_pkg::INDEX_W'(pos_reg);
                    end
                    pos_next   = pos_reg + 1'b1;
                    state_next = pcs_pkg::TS_DONE;
                end
            end
            pcs_pkg::TS_DONE:
            begin
                if (!last_reg)
                begin
                    state_next = pcs_pkg::TS_IDLE;
                end
                else if (out_free)
                begin
                    load_out          = 1'b1;
                    result_valid_next = 1'b1;
                    run_score_next    = pcs_pkg::SCORE_MIN;
                    run_idx_next      = '0;
                    pos_next          = '0;
                    state_next        = pcs_pkg::TS_IDLE;
                end
            end
            default:
            begin
                state_next = pcs_pkg::TS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pcs_pkg::TS_IDLE;
            weight_reg       <= pcs_pkg::WEIGHT_RESET;
            pos_reg          <= '0;
            run_score_reg    <= pcs_pkg::SCORE_MIN;
            run_idx_reg      <= '0;
            last_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pos_reg          <= pos_next;
            run_score_reg    <= run_score_next;
            run_idx_reg      <= run_idx_next;
            last_reg         <= last_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                weight_reg <= pwdata[pcs_pkg::WEIGHT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            chosen_index_reg <= run_idx_reg;
            best_score_reg   <= run_score_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign chosen_index = chosen_index_reg;
    assign best_score   = best_score_reg;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of puct_child_select_unit: child streams in, node winners checked.
module tb_top;

    typedef struct packed {
        logic [pcs_pkg::INDEX_W-1:0] index;
        pcs_pkg::score_t             score;
    } node_winner_t;

    logic                                clk;
    logic                                rst_n = 1'b0;

    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [pcs_pkg::APB_ADDR_W-1:0]      paddr = '0;
    logic [31:0]                         pwdata = '0;
    logic [31:0]                         prdata;
    logic                                pready;

    logic                                child_valid = 1'b0;
    logic                                child_stall;
    logic signed [pcs_pkg::SUM_W-1:0]    child_value_sum = '0;
    logic [pcs_pkg::VIS_W-1:0]           child_visits = '0;
    logic [pcs_pkg::PRIOR_W-1:0]         child_prior = '0;
    logic [pcs_pkg::VIS_W-1:0]           parent_visits = '0;
    logic                                last_child = 1'b0;

    logic                                result_valid;
    logic                                result_stall = 1'b0;
    logic [pcs_pkg::INDEX_W-1:0]         chosen_index;
    logic signed [pcs_pkg::SCORE_W-1:0]  best_score;

    node_winner_t                        node_winners_q[$];
    logic [pcs_pkg::WEIGHT_W-1:0]        weight_shadow = pcs_pkg::WEIGHT_RESET;
    pcs_pkg::score_t                     lead_score = pcs_pkg::SCORE_MIN;
    logic [pcs_pkg::INDEX_W-1:0]         lead_index = '0;
    int unsigned                         child_count = 0;

    int unsigned                         send_idle_pct = 0;
    int unsigned                         recv_stall_pct = 0;
    int unsigned                         error_count = 0;
    int unsigned                         children_sent = 0;
    int unsigned                         results_checked = 0;
    int unsigned                         weight_writes = 0;

    puct_child_select_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .child_valid     (child_valid),
        .child_stall     (child_stall),
        .child_value_sum (child_value_sum),
        .child_visits    (child_visits),
        .child_prior     (child_prior),
        .parent_visits   (parent_visits),
        .last_child      (last_child),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .chosen_index    (chosen_index),
        .best_score      (best_score)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic pcs_pkg::score_t score_child(
        logic signed [pcs_pkg::SUM_W-1:0] vsum,
        logic [pcs_pkg::VIS_W-1:0]        visits,
        logic [pcs_pkg::PRIOR_W-1:0]      prior,
        logic [pcs_pkg::VIS_W-1:0]        parent,
        logic [pcs_pkg::WEIGHT_W-1:0]     weight
    );
        logic [pcs_pkg::SUM_W-1:0]  mag;
        longint unsigned   vis;
        longint unsigned   quot;
        longint unsigned   radicand;
        longint unsigned   root;
        longint unsigned   trial;
        longint unsigned   num;
        longint unsigned   den;
        longint            total;
        vis = {48'd0, visits & pcs_pkg::VISIT_MASK};
        mag = vsum[pcs_pkg::SUM_W-1] ? ~vsum + 33'd1 : vsum;
        quot = (vis == 0) ? 64'd0 : {31'd0, mag} / vis;
        radicand = {16'd0, parent & pcs_pkg::VISIT_MASK, 32'd0};
        root = 0;
        for (int b = 24; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        num = {47'd0, prior} * {48'd0, weight} * root;
        den = (vis + 64'd1) << pcs_pkg::E_SHIFT;
        total = (vsum[pcs_pkg::SUM_W-1] ? -longint'(quot) : longint'(quot))
              + longint'(num / den);
        if (total > longint'(pcs_pkg::SCORE_MAX))
            return pcs_pkg::SCORE_MAX;
        if (total < longint'(pcs_pkg::SCORE_MIN))
            return pcs_pkg::SCORE_MIN;
        return pcs_pkg::score_t'(total);
    endfunction

    task automatic report_mismatch(string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // one child transfer; the expected winner is queued when the node ends
    task automatic send_child(
        logic signed [pcs_pkg::SUM_W-1:0] vsum,
        logic [pcs_pkg::VIS_W-1:0]        visits,
        logic [pcs_pkg::PRIOR_W-1:0]      prior,
        logic [pcs_pkg::VIS_W-1:0]        parent,
        logic                             last
    );
        pcs_pkg::score_t s;
        node_winner_t    winner;
        while ($urandom_range(99) < send_idle_pct)
        begin
            child_valid <= 1'b0;
            @(posedge clk);
        end
        child_valid     <= 1'b1;
        child_value_sum <= vsum;
        child_visits    <= visits;
        child_prior     <= prior;
        parent_visits   <= parent;
        last_child      <= last;
        @(posedge clk);
        while (child_stall)
            @(posedge clk);
        children_sent++;
        if (child_count < pcs_pkg::MAX_CHILDREN)
        begin
            s = score_child(vsum, visits, prior, parent, weight_shadow);
            if (child_count == 0 || s > lead_score)
            begin
                lead_score = s;
                lead_index = child_count[pcs_pkg::INDEX_W-1:0];
            end
            child_count++;
        end
        if (last)
        begin
            winner.index   = lead_index;
            winner.score   = lead_score;
            node_winners_q = {node_winners_q, winner};
            lead_score     = pcs_pkg::SCORE_MIN;
            lead_index     = '0;
            child_count    = 0;
        end
    endtask

    task automatic pause_until_drained(int unsigned settle);
        child_valid <= 1'b0;
        while (node_winners_q.size() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic write_weight(logic [pcs_pkg::WEIGHT_W-1:0] weight);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pcs_pkg::APB_ADDR_W'(4 * pcs_pkg::REG_EXPLORATION);
        pwdata  <= {16'd0, weight};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        weight_shadow = weight;
        weight_writes++;
        @(posedge clk);
        if (prdata !== {16'd0, weight})
            report_mismatch($sformatf("exploration_weight reads %0h, expected %0h",
                                      prdata, weight));
    endtask

    task automatic draw_child(
        output logic signed [pcs_pkg::SUM_W-1:0] vsum,
        output logic [pcs_pkg::VIS_W-1:0]        visits,
        output logic [pcs_pkg::PRIOR_W-1:0]      prior
    );
        longint scaled;
        case ($urandom_range(3))
            0: visits = '0;
            1: visits = pcs_pkg::VIS_W'($urandom_range(1, 20));
            default: visits = pcs_pkg::VIS_W'($urandom_range(65535));
        endcase
        case ($urandom_range(4))
            0: vsum = {1'($urandom_range(1)), $urandom()};
            1:
            begin
                case ($urandom_range(3))
                    0: vsum = 33'sh0FFFF0000;
                    1: vsum = -33'sh0FFFF0000;
                    2: vsum = 33'sh100000000;
                    default: vsum = -33'sd1;
                endcase
            end
            default:
            begin
                scaled = longint'(visits) * (longint'($urandom_range(131072)) - 64'sd65536);
                vsum = scaled[pcs_pkg::SUM_W-1:0];
            end
        endcase
        prior = ($urandom_range(7) == 0) ? pcs_pkg::PRIOR_W'($urandom())
                                         : pcs_pkg::PRIOR_W'($urandom_range(65536));
    endtask

    task automatic test_edge_children();
        send_idle_pct  = 25;
        recv_stall_pct = 52;
        send_child(33'sd0, 16'd0, 17'd0, 16'd0, 1'b1);
        send_child(33'sh0FFFFFFFF, 16'd1, 17'd0, 16'd0, 1'b0);
        send_child(33'sh0FFFFFFFF, 16'd1, 17'd0, 16'd0, 1'b0);
        send_child(33'sh100000000, 16'd1, 17'd0, 16'd0, 1'b1);
        send_child(33'sh100000000, 16'd1, 17'd0, 16'd0, 1'b0);
        send_child(33'sh100000000, 16'd1, 17'd0, 16'd0, 1'b1);
        send_child(33'sh0FFFF0000, 16'd0, 17'd65536, 16'd65535, 1'b0);
        send_child(33'sh0FFFF0000, 16'd65535, 17'h1FFFF, 16'd65535, 1'b0);
        send_child(-33'sd1, 16'd0, 17'd0, 16'd65535, 1'b1);
        send_child(33'sd100, 16'd1, 17'd0, 16'd100, 1'b0);
        send_child(33'sd5000, 16'd1, 17'd0, 16'd100, 1'b0);
        send_child(33'sd5000, 16'd1, 17'd0, 16'd100, 1'b0);
        send_child(-33'sd5, 16'd1, 17'd0, 16'd100, 1'b1);
        send_child(33'sh1_0000_0001, 16'd3, 17'h1FFFF, 16'd1, 1'b0);
        send_child(33'sd0, 16'd65535, 17'h10000, 16'd65535, 1'b1);
    endtask

    task automatic test_random_nodes();
        logic signed [pcs_pkg::SUM_W-1:0] vsum;
        logic [pcs_pkg::VIS_W-1:0]        visits;
        logic [pcs_pkg::PRIOR_W-1:0]      prior;
        logic [pcs_pkg::VIS_W-1:0]        parent;
        logic [pcs_pkg::VIS_W-1:0]        parent_now;
        int unsigned                      sent;
        int unsigned                      node_size;
        for (int phase = 0; phase < 6; phase++)
        begin
            pause_until_drained(100);
            case (phase)
                0: write_weight(16'hFFFF);
                1: write_weight(16'h0000);
                default: write_weight(pcs_pkg::WEIGHT_W'($urandom_range(65535)));
            endcase
            send_idle_pct  = (phase < 2) ? 25 : (phase < 4) ? 52 : 0;
            recv_stall_pct = (phase < 2) ? 52 : (phase < 4) ? 25 : 0;
            sent = 0;
            while (sent < 25)
            begin
                parent = ($urandom_range(3) == 0)
                       ? pcs_pkg::VIS_W'($urandom_range(50))
                       : pcs_pkg::VIS_W'($urandom_range(65535));
                node_size = ($urandom_range(9) == 0) ? $urandom_range(8, 24)
                                                     : $urandom_range(1, 6);
                for (int k = 0; k < node_size; k++)
                begin
                    // repeat the previous child now and then to force ties
                    if (k == 0 || $urandom_range(9) != 0)
                        draw_child(vsum, visits, prior);
                    parent_now = ($urandom_range(6) == 0)
                               ? pcs_pkg::VIS_W'($urandom_range(65535))
                               : parent;
                    send_child(vsum, visits, prior, parent_now, k == node_size - 1);
                end
                sent += node_size;
                if ($urandom_range(19) == 0)
                    pause_until_drained(0);
            end
        end
    endtask

    task automatic test_too_many_children();
        logic signed [pcs_pkg::SUM_W-1:0] vsum;
        logic [pcs_pkg::VIS_W-1:0]        visits;
        logic [pcs_pkg::PRIOR_W-1:0]      prior;
        logic [pcs_pkg::VIS_W-1:0]        parent;
        pause_until_drained(100);
        write_weight(pcs_pkg::WEIGHT_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        parent = pcs_pkg::VIS_W'($urandom_range(65535));
        for (int k = 0; k < 264; k++)
        begin
            draw_child(vsum, visits, prior);
            // past the child limit these would win if they were still compared
            if (k >= pcs_pkg::MAX_CHILDREN)
            begin
                vsum   = 33'sh0FFFFFFFF;
                visits = 16'd1;
            end
            send_child(vsum, visits, prior, parent, k == 263);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        node_winner_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (node_winners_q.size() == 0)
                report_mismatch($sformatf("unexpected result index %0d score %0d",
                                          chosen_index, best_score));
            else
            begin
                want = node_winners_q.pop_front();
                if (chosen_index !== want.index)
                    report_mismatch($sformatf("chosen_index %0d, expected %0d",
                                              chosen_index, want.index));
                if (best_score !== want.score)
                    report_mismatch($sformatf("best_score %0d, expected %0d",
                                              best_score, want.score));
                results_checked++;
            end
        end
        result_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        test_edge_children();
        test_random_nodes();
        test_too_many_children();
        pause_until_drained(100);
        $display("tb: %0d children sent under %0d weight writes, %0d node results checked",
                 children_sent, weight_writes, results_checked);
        $display("tb: covered edge children, random nodes with ties, and an oversized node");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/pcs_pkg.sv
hdl/pcs_div_serial.sv
hdl/pcs_sqrt_serial.sv
hdl/pcs_score_core.sv
hdl/puct_child_select_unit.sv
tb/tb_top.sv
